/* hw/rtl/radix_conversion_unit_assert.svh */
// Assertion macros for the radix conversion unit.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef RADIX_CONVERSION_UNIT_ASSERT_SVH
`define RADIX_CONVERSION_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RCU_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rcu assertion failed");
`define RCU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcu assertion failed");
`else
`define RCU_ASSERT(lbl, cond)
`define RCU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/rcu_pkg.sv */
// Shared types, constants and character helpers of the radix conversion unit.
// No dependencies.
`timescale 1ns / 1ps
package rcu_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned BASE_W    = 6;
  localparam int unsigned DIGIT_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IN_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_BASE = 2'd1;

  localparam logic [BASE_W-1:0] BASE_MIN       = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX       = 6'd36;
  localparam logic [BASE_W-1:0] IN_BASE_RESET  = 6'd10;
  localparam logic [BASE_W-1:0] OUT_BASE_RESET = 6'd2;

  localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHR_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CHR_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CHR_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CHR_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] UPPER_OFS = 8'd55;
  localparam logic [CHAR_W-1:0] LOWER_OFS = 8'd87;
  localparam logic [DIGIT_W-1:0] DEC_MAX  = 6'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_READ,
    ST_LOAD,
    ST_EMIT
  } rcu_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rcu_div_stat_t;

  function automatic logic [DIGIT_W-1:0] char_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = '0;
    if (c >= CHR_ZERO && c <= CHR_NINE) begin
      v = c - CHR_ZERO;
    end else if (c >= CHR_UA && c <= CHR_UZ) begin
      v = c - UPPER_OFS;
    end else if (c >= CHR_LA && c <= CHR_LZ) begin
      v = c - LOWER_OFS;
    end
    return v[DIGIT_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {{(CHAR_W - DIGIT_W){1'b0}}, d};
    if (d <= DEC_MAX) begin
      return dw + CHR_ZERO;
    end
    return dw + UPPER_OFS;
  endfunction

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) begin
      return BASE_MIN;
    end
    if (b > BASE_MAX) begin
      return BASE_MAX;
    end
    return b;
  endfunction

endpackage

/* hw/rtl/rcu_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module rcu_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/rcu_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, small base divisor.
// Depends on rcu_pkg.
`timescale 1ns / 1ps
module rcu_div #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [VALUE_WIDTH-1:0]        dividend,
  input  logic [rcu_pkg::BASE_W-1:0]    divisor,
  output logic [VALUE_WIDTH-1:0]        quot,
  output logic [rcu_pkg::DIGIT_W-1:0]   rem,
  output rcu_pkg::rcu_div_stat_t        stat
);
  import rcu_pkg::*;

  localparam int unsigned CntW = $clog2(VALUE_WIDTH);
  localparam logic [CntW-1:0] LastStep = CntW'(VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] quot_r, quot_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [CntW-1:0]        cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DIGIT_W:0]       trial;
  logic [DIGIT_W:0]       trial_sub;
  logic                   fits;

  always_comb begin
    trial     = {rem_r, quot_r[VALUE_WIDTH-1]};
    trial_sub = trial - {1'b0, divisor};
    fits      = trial >= {1'b0, divisor};
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = {quot_r[VALUE_WIDTH-2:0], fits};
      rem_nxt  = fits ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      cnt_nxt  = cnt_r + CntW'(1);
      if (cnt_r == LastStep) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quot      = quot_r;
  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* hw/rtl/radix_conversion_unit.sv */
// Radix conversion unit: folds digit characters into a value and emits it in another base.
// Depends on rcu_pkg, rcu_div, rcu_ram and radix_conversion_unit_assert.svh.
//
// Input items are ASCII digit characters of one number, most significant first, on
// in_valid/in_ready; in_last_in marks the final character. While idle, one character
// is accepted every cycle and folded in by one multiply-add.
// After the final character, the value is divided by the output base repeatedly.
// Each digit passes through the bit-serial divider, and the
// remainders go into the digit store.
// Result items are uppercase ASCII digits on out_valid/out_ready, most significant
// first, with out_last_out on the final digit. Each digit goes through the states
// ST_READ, ST_LOAD and ST_EMIT and the registered read of the digit store; a stall
// of the receiver holds the current digit in the output register.
// No new number is accepted until the last digit has been taken.
// The bases are written on the cfg_ channel, index 0 for the input base and 1 for
// the output base. Reset returns the bases to 10 and 2 and clears the value.
`timescale 1ns / 1ps
`include "radix_conversion_unit_assert.svh"
module radix_conversion_unit #(
  parameter int unsigned VALUE_WIDTH    = 64,
  parameter int unsigned MAX_OUT_DIGITS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rcu_pkg::CHAR_W-1:0]      in_char_in,
  input  logic                            in_last_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rcu_pkg::CHAR_W-1:0]      out_char_out,
  output logic                            out_last_out,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcu_pkg::BASE_W-1:0]      cfg_data
);
  import rcu_pkg::*;

  localparam int unsigned AW = $clog2(MAX_OUT_DIGITS);
  localparam int unsigned CW = $clog2(MAX_OUT_DIGITS + 1);
  localparam int unsigned PW = VALUE_WIDTH + BASE_W;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_OUT_DIGITS);

  rcu_state_t             state_r, state_nxt;
  logic [BASE_W-1:0]      in_base_r, in_base_nxt;
  logic [BASE_W-1:0]      out_base_r, out_base_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [BASE_W-1:0]      ib;
  logic [BASE_W-1:0]      ob;
  logic [PW-1:0]          prod;
  logic [PW-1:0]          sum;
  logic [CW-1:0]          cnt_inc;
  logic                   more;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [DIGIT_W-1:0]     div_rem;
  rcu_div_stat_t          div_stat;
  logic                   ram_we;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [DIGIT_W-1:0]     ram_rdata;
  logic                   in_fire;
  logic                   out_fire;

  assign ib        = clamp_base(in_base_r);
  assign ob        = clamp_base(out_base_r);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign cnt_inc   = cnt_r + CW'(1);
  assign more      = (div_quot != '0) && (cnt_inc < MaxCnt);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_last_in) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = more ? ST_START : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          state_nxt = out_last_r ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready  = 1'b1;
      ST_START: div_start = 1'b1;
      ST_DIV:   ram_we    = div_stat.done;
      ST_READ:  ram_re    = 1'b1;
      ST_LOAD:  ;
      ST_EMIT:  out_valid = 1'b1;
      default:  ;
    endcase
  end

  always_comb begin
    prod         = {{BASE_W{1'b0}}, acc_r} * {{VALUE_WIDTH{1'b0}}, ib};
    sum          = prod + PW'(char_value(in_char_in));
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    div_dividend = (cnt_r == '0) ? acc_r : div_quot;
    ram_raddr    = AW'(cnt_r - CW'(1));
    if (in_fire) begin
      acc_nxt = sum[VALUE_WIDTH-1:0];
      if (in_last_in) begin
        cnt_nxt = '0;
      end
    end
    if (div_start && cnt_r == '0) begin
      acc_nxt = '0;
    end
    if (ram_we) begin
      cnt_nxt = cnt_inc;
    end
    if (state_r == ST_LOAD) begin
      out_char_nxt = digit_char(ram_rdata);
      out_last_nxt = (cnt_r == CW'(1));
    end
    if (out_fire) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    in_base_nxt  = in_base_r;
    out_base_nxt = out_base_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IN_BASE:  in_base_nxt  = cfg_data;
        REG_OUT_BASE: out_base_nxt = cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_base_r  <= IN_BASE_RESET;
      out_base_r <= OUT_BASE_RESET;
      acc_r      <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      in_base_r  <= in_base_nxt;
      out_base_r <= out_base_nxt;
      acc_r      <= acc_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  rcu_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (ob),
    .quot     (div_quot),
    .rem      (div_rem),
    .stat     (div_stat)
  );

  rcu_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(MAX_OUT_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (div_rem),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_char_out = out_char_r;
  assign out_last_out = out_last_r;

  `RCU_ASSERT(a_no_overlap, !(in_ready && out_valid))
  `RCU_ASSERT(a_start_free, !(div_start && div_stat.busy))
  `RCU_ASSERT(a_count_bound, cnt_r <= MaxCnt)
  `RCU_ASSERT_NEXT(a_last_idle, out_valid && out_ready && out_last_out, in_ready)

endmodule
